FILE: rtl/core/wppm_pkg.sv
// ----------------------------------------------------------------------------
// wppm_pkg: shared definitions of the windowed peak-to-peak monitor
// Configuration register indexes, reset values, default widths and the
// control bundle that drives the per-signal trackers.
// ----------------------------------------------------------------------------
package wppm_pkg;

    localparam int DEF_SAMPLE_BITS = 16;
    localparam int DEF_COUNT_BITS  = 16;
    localparam int NUM_SIGNALS     = 3;

    // Configuration port
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_TICKS = 1'b0,
        CFG_START_DELAY  = 1'b1
    } t_cfg_idx;

    // 60 * 100 and 30 * 100 ticks
    localparam logic [CFG_W-1:0] WINDOW_TICKS_RST = CFG_W'(60 * 100);
    localparam logic [CFG_W-1:0] START_DELAY_RST  = CFG_W'(30 * 100);

    // One step of every tracker, already qualified by the pipeline advance.
    typedef struct packed {
        logic restart;  // clear trackers and published spans
        logic track;    // fold in the sample of this tick
        logic close;    // publish spans and clear trackers before folding
    } t_trk_ctrl;

endpackage

FILE: rtl/core/wppm_tracker.sv
// ----------------------------------------------------------------------------
// wppm_tracker: running min/max tracker of one signal
// Keeps the minimum and maximum of the valid samples in the current window
// and holds the span published when the last window closed.
// ----------------------------------------------------------------------------
module wppm_tracker #(
    parameter int SAMPLE_BITS = wppm_pkg::DEF_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  wppm_pkg::t_trk_ctrl           i_ctrl,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_ok,
    output logic        [SAMPLE_BITS-1:0] o_span,
    output logic                          o_span_ok
);
    import wppm_pkg::*;

    logic signed [SAMPLE_BITS-1:0] r_min, r_max, n_min, n_max;
    logic                          r_seen, n_seen;
    logic        [SAMPLE_BITS-1:0] r_span, n_span;
    logic                          r_span_ok, n_span_ok;

    logic signed [SAMPLE_BITS-1:0] w_base_min, w_base_max;
    logic                          w_base_seen;

    always_comb begin
        // A closing tick starts the new window from empty trackers.
        w_base_seen = i_ctrl.close ? 1'b0 : r_seen;
        w_base_min  = i_ctrl.close ? '0 : r_min;
        w_base_max  = i_ctrl.close ? '0 : r_max;

        n_span    = r_span;
        n_span_ok = r_span_ok;
        if (i_ctrl.close) begin
            n_span    = r_seen ? SAMPLE_BITS'(r_max - r_min) : '0;
            n_span_ok = r_seen;
        end

        n_min  = w_base_min;
        n_max  = w_base_max;
        n_seen = w_base_seen;
        if (i_ok) begin
            if (!w_base_seen || i_sample < w_base_min) begin
                n_min = i_sample;
            end
            if (!w_base_seen || i_sample > w_base_max) begin
                n_max = i_sample;
            end
            n_seen = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.restart) begin
            r_min     <= '0;
            r_max     <= '0;
            r_seen    <= 1'b0;
            r_span    <= '0;
            r_span_ok <= 1'b0;
        end else if (i_ctrl.track) begin
            r_min     <= n_min;
            r_max     <= n_max;
            r_seen    <= n_seen;
            r_span    <= n_span;
            r_span_ok <= n_span_ok;
        end
    end

    assign o_span    = r_span;
    assign o_span_ok = r_span_ok;

    // An invalid span always reads as zero.
    a_span_zero_when_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_span_ok |-> (r_span == '0))
        else $error("span nonzero while marked invalid");

    // The trackers are never ordered wrongly once a sample was seen.
    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen |-> (r_min <= r_max))
        else $error("tracked minimum above maximum");

    // A tick that does not close a window leaves the published span alone.
    a_span_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_ctrl.close && !i_ctrl.restart) |=> $stable(r_span) && $stable(r_span_ok))
        else $error("span changed without a window close");

endmodule

FILE: rtl/core/windowed_peak_to_peak_monitor_top.sv
// ----------------------------------------------------------------------------
// windowed_peak_to_peak_monitor_top: peak-to-peak monitor of three signals
//
// Slave stream s_axis carries one tick per transaction: three signed samples
// with valid flags in tdata, and in tuser the request kind (0 = sample tick,
// 1 = restart). Master stream m_axis returns one transaction per tick with the
// last published spans and their valid flags, and window_closed in tuser.
// Configuration: i_cfg_wr_en writes i_cfg_wdata to register i_cfg_index
// (0 = window length in ticks, 1 = start delay in ticks); write while idle.
// An accepted tick is loaded into the input register and then passes on to
// the trackers, whose span registers form the result. Throughput is one tick
// per cycle while the receiver does not stall; the stage enables follow
// m_axis_tready, so a stall of the receiver holds the result and the input
// register and back-pressure reaches s_axis_tready in the same cycle.
// Reset (synchronous, active low) restores the register defaults and acts as
// a restart: trackers and spans cleared, start delay reloaded.
// ----------------------------------------------------------------------------
module windowed_peak_to_peak_monitor_top #(
    parameter  int SAMPLE_BITS = wppm_pkg::DEF_SAMPLE_BITS,
    parameter  int COUNT_BITS  = wppm_pkg::DEF_COUNT_BITS,
    localparam int LANES_W     = wppm_pkg::NUM_SIGNALS * (SAMPLE_BITS + 1),
    localparam int TDATA_W     = ((LANES_W + 7) / 8) * 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_wr_en,
    input  logic [wppm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [wppm_pkg::CFG_W-1:0]     i_cfg_wdata,
    // input ticks
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // low to high: inlet_sample, inlet_ok, outlet_sample, outlet_ok,
    // meniscus_sample, meniscus_ok, zero padding
    input  logic [TDATA_W-1:0]             s_axis_tdata,
    // req_type
    input  logic                           s_axis_tuser,
    // results
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // low to high: inlet_span, inlet_span_ok, outlet_span, outlet_span_ok,
    // meniscus_span, meniscus_span_ok, zero padding
    output logic [TDATA_W-1:0]             m_axis_tdata,
    // window_closed
    output logic                           m_axis_tuser
);
    import wppm_pkg::*;

    localparam int LANE_W = SAMPLE_BITS + 1;
    localparam int CMP_W  = ((COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W) + 1;

    // configuration registers
    logic [CFG_W-1:0] r_window_ticks, r_start_delay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_ticks <= WINDOW_TICKS_RST;
            r_start_delay  <= START_DELAY_RST;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_WINDOW_TICKS: r_window_ticks <= i_cfg_wdata;
                CFG_START_DELAY:  r_start_delay  <= i_cfg_wdata;
                default:          ;
            endcase
        end
    end

    // pipeline control
    logic               r_in_vld, r_out_vld, r_in_req, r_closed, n_closed;
    logic [LANES_W-1:0] r_in_data;
    logic               w_out_en, w_adv;

    assign w_out_en      = !r_out_vld || m_axis_tready;
    assign w_adv         = r_in_vld && w_out_en;
    assign s_axis_tready = !r_in_vld || w_out_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_data <= s_axis_tdata[LANES_W-1:0];
            r_in_req  <= s_axis_tuser;
        end
    end

    // delay and window counters
    logic [COUNT_BITS-1:0] r_delay_left, r_window_count;
    logic [CMP_W-1:0]      w_next;
    logic                  w_delaying, w_close;
    t_trk_ctrl             w_ctrl;

    assign w_delaying = (r_delay_left != '0);
    assign w_next     = CMP_W'(r_window_count) + CMP_W'(1);
    assign w_close    = w_next > CMP_W'(r_window_ticks);

    always_comb begin
        w_ctrl.restart = w_adv && r_in_req;
        w_ctrl.track   = w_adv && !r_in_req && !w_delaying;
        w_ctrl.close   = w_ctrl.track && w_close;
        n_closed       = w_ctrl.close;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_left   <= COUNT_BITS'(START_DELAY_RST);
            r_window_count <= '0;
            r_out_vld      <= 1'b0;
            r_closed       <= 1'b0;
        end else begin
            if (w_out_en) begin
                r_out_vld <= r_in_vld;
            end
            if (w_adv) begin
                r_closed <= n_closed;
                if (r_in_req) begin
                    r_delay_left   <= COUNT_BITS'(r_start_delay);
                    r_window_count <= '0;
                end else if (w_delaying) begin
                    r_delay_left <= r_delay_left - COUNT_BITS'(1);
                end else if (w_close) begin
                    r_window_count <= '0;
                end else begin
                    r_window_count <= w_next[COUNT_BITS-1:0];
                end
            end
        end
    end

    // per-signal trackers; their span registers are the result register
    logic [NUM_SIGNALS-1:0]  w_span_ok;
    logic [LANES_W-1:0]      w_result;

    for (genvar g = 0; g < NUM_SIGNALS; g++) begin : g_lane
        logic [SAMPLE_BITS-1:0] w_span;

        wppm_tracker #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_tracker (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctrl    (w_ctrl),
            .i_sample  (r_in_data[g*LANE_W +: SAMPLE_BITS]),
            .i_ok      (r_in_data[g*LANE_W + SAMPLE_BITS]),
            .o_span    (w_span),
            .o_span_ok (w_span_ok[g])
        );

        assign w_result[g*LANE_W +: LANE_W] = {w_span_ok[g], w_span};
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = TDATA_W'(w_result);
    assign m_axis_tuser  = r_closed;

    // A restart leaves every span invalid and reloads the start delay.
    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.restart |=> (w_span_ok == '0) && !r_closed
                           && (r_delay_left == COUNT_BITS'($past(r_start_delay))))
        else $error("restart did not clear the monitor");

    // No window closes while the start delay is still running.
    a_no_close_in_delay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && !r_in_req && w_delaying) |=> !r_closed)
        else $error("window closed during start delay");

    // A closing tick restarts the window count.
    a_close_resets_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.close |=> (r_window_count == '0) && r_closed && r_out_vld)
        else $error("window close did not restart the count");

    // State only moves when an item passes into the result stage.
    a_state_holds_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_window_count) && $stable(r_delay_left) && $stable(r_closed))
        else $error("counters moved without a transaction");

endmodule

FILE: test/windowed_peak_to_peak_monitor_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_peak_to_peak_monitor_top_tb: self-checking bench of the monitor
// A table of directed ticks, restarts and register writes is walked first,
// then a short phase with the full-range window, then random phases with
// mostly short windows. Every accepted tick is run through a local model of
// the trackers and the expected spans are queued; each result transaction
// is compared with the oldest entry. The sender idles in bursts and the
// receiver stalls on its own pattern, with one long hold-off.
// ----------------------------------------------------------------------------
module windowed_peak_to_peak_monitor_top_tb;
    import wppm_pkg::*;

    localparam int SB      = DEF_SAMPLE_BITS;
    localparam int CB      = DEF_COUNT_BITS;
    localparam int NS      = NUM_SIGNALS;
    localparam int LANE    = SB + 1;
    localparam int TDATA_W = ((NS * LANE + 7) / 8) * 8;

    localparam logic REQ_TICK    = 1'b0;
    localparam logic REQ_RESTART = 1'b1;

    localparam int STALL_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 400;
    localparam int TAIL_CYCLES   = 10;
    localparam int REPORT_MAX    = 10;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 36;
    localparam int FULL_ITEMS    = 16;
    localparam logic [CB-1:0] FULL_WINDOW = '1;

    typedef struct packed {
        logic                   req_type;
        logic [NS-1:0]          ok;     // bit 0 inlet, 1 outlet, 2 meniscus
        logic [NS-1:0][SB-1:0]  smp;
    } t_tick;

    typedef struct packed {
        logic                   closed;
        logic [NS-1:0]          ok;
        logic [NS-1:0][SB-1:0]  span;
    } t_spans;

    typedef enum logic [1:0] {
        ROW_TICK,
        ROW_RESTART,
        ROW_WRITE
    } t_row_kind;

    // For a register write, a holds the register index and b the value.
    typedef struct packed {
        t_row_kind      kind;
        logic [SB-1:0]  a;
        logic [SB-1:0]  b;
        logic [SB-1:0]  c;
        logic [NS-1:0]  ok;
        logic           typed;
        logic [SB-1:0]  e_in;
        logic [SB-1:0]  e_out;
        logic [SB-1:0]  e_men;
        logic [NS-1:0]  e_ok;
        logic           e_closed;
    } t_row;

    localparam int ROWS = 26;

    t_row plan [ROWS] = '{
        // default registers: still inside the start delay
        '{ROW_TICK,    16'h7FFF, 16'h8000, 16'h0001, 3'b111, 1'b1,
          16'h0000, 16'h0000, 16'h0000, 3'b000, 1'b0},
        '{ROW_RESTART, 16'h1234, 16'hFEDC, 16'h8000, 3'b111, 1'b1,
          16'h0000, 16'h0000, 16'h0000, 3'b000, 1'b0},
        // window of zero: every tracking tick closes a window
        '{ROW_WRITE,   16'(CFG_WINDOW_TICKS), 16'd0, 16'h0, 3'b000, 1'b0,
          16'h0000, 16'h0000, 16'h0000, 3'b000, 1'b0},
        '{ROW_WRITE,   16'(CFG_START_DELAY),  16'd2, 16'h0, 3'b000, 1'b0,
          16'h0000, 16'h0000, 16'h0000, 3'b000, 1'b0},
        '{ROW_RESTART, 16'h0000, 16'h0000, 16'h0000, 3'b000, 1'b1,
          16'h0000, 16'h0000, 16'h0000, 3'b000, 1'b0},
        '{ROW_TICK,    16'h7FFF, 16'h7FFF, 16'h7FFF, 3'b111, 1'b1,
          16'h0000, 16'h0000, 16'h0000, 3'b000, 1'b0},
        '{ROW_TICK,    16'h8000, 16'h8000, 16'h8000, 3'b111, 1'b1,
          16'h0000, 16'h0000, 16'h0000, 3'b000, 1'b0},
        '{ROW_TICK,    16'h7FFF, 16'h8000, 16'h0000, 3'b011, 1'b1,
          16'h0000, 16'h0000, 16'h0000, 3'b000, 1'b1},
        '{ROW_TICK,    16'h8000, 16'h7FFF, 16'h0001, 3'b111, 1'b1,
          16'h0000, 16'h0000, 16'h0000, 3'b011, 1'b1},
        // window of one tick, no start delay
        '{ROW_WRITE,   16'(CFG_WINDOW_TICKS), 16'd1, 16'h0, 3'b000, 1'b0,
          16'h0000, 16'h0000, 16'h0000, 3'b000, 1'b0},
        '{ROW_WRITE,   16'(CFG_START_DELAY),  16'd0, 16'h0, 3'b000, 1'b0,
          16'h0000, 16'h0000, 16'h0000, 3'b000, 1'b0},
        '{ROW_RESTART, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'b111, 1'b1,
          16'h0000, 16'h0000, 16'h0000, 3'b000, 1'b0},
        '{ROW_TICK,    16'h8000, 16'h0000, 16'hFFFF, 3'b011, 1'b1,
          16'h0000, 16'h0000, 16'h0000, 3'b000, 1'b0},
        '{ROW_TICK,    16'h7FFF, 16'h0001, 16'h0005, 3'b111, 1'b0,
          16'h0000, 16'h0000, 16'h0000, 3'b000, 1'b0},
        '{ROW_TICK,    16'h8000, 16'h7FFF, 16'hFFFB, 3'b101, 1'b0,
          16'h0000, 16'h0000, 16'h0000, 3'b000, 1'b0},
        // full signed range in one window gives the widest span
        '{ROW_TICK,    16'h0000, 16'h0000, 16'h0000, 3'b000, 1'b1,
          16'hFFFF, 16'h0000, 16'h000A, 3'b111, 1'b1},
        // window lowered below the running count closes on the next tick
        '{ROW_WRITE,   16'(CFG_WINDOW_TICKS), 16'd3, 16'h0, 3'b000, 1'b0,
          16'h0000, 16'h0000, 16'h0000, 3'b000, 1'b0},
        '{ROW_TICK,    16'h0010, 16'hFFF0, 16'h0100, 3'b111, 1'b0,
          16'h0000, 16'h0000, 16'h0000, 3'b000, 1'b0},
        '{ROW_TICK,    16'h0020, 16'hFFE0, 16'h0200, 3'b110, 1'b0,
          16'h0000, 16'h0000, 16'h0000, 3'b000, 1'b0},
        '{ROW_TICK,    16'hFFF0, 16'h0030, 16'h0300, 3'b011, 1'b0,
          16'h0000, 16'h0000, 16'h0000, 3'b000, 1'b0},
        '{ROW_WRITE,   16'(CFG_WINDOW_TICKS), 16'd1, 16'h0, 3'b000, 1'b0,
          16'h0000, 16'h0000, 16'h0000, 3'b000, 1'b0},
        '{ROW_TICK,    16'h0001, 16'h0002, 16'h0003, 3'b111, 1'b0,
          16'h0000, 16'h0000, 16'h0000, 3'b000, 1'b0},
        // longest start delay
        '{ROW_WRITE,   16'(CFG_START_DELAY),  16'hFFFF, 16'h0, 3'b000, 1'b0,
          16'h0000, 16'h0000, 16'h0000, 3'b000, 1'b0},
        '{ROW_RESTART, 16'h5555, 16'hAAAA, 16'h5555, 3'b101, 1'b1,
          16'h0000, 16'h0000, 16'h0000, 3'b000, 1'b0},
        '{ROW_TICK,    16'hAAAA, 16'h5555, 16'hAAAA, 3'b111, 1'b1,
          16'h0000, 16'h0000, 16'h0000, 3'b000, 1'b0},
        '{ROW_TICK,    16'h0000, 16'h0000, 16'h0000, 3'b000, 1'b1,
          16'h0000, 16'h0000, 16'h0000, 3'b000, 1'b0}
    };

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [CFG_W-1:0]     i_cfg_wdata   = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // low to high: inlet_sample, inlet_ok, outlet_sample, outlet_ok,
    // meniscus_sample, meniscus_ok, zero padding
    logic [TDATA_W-1:0]   s_axis_tdata  = '0;
    // req_type
    logic                 s_axis_tuser  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // low to high: inlet_span, inlet_span_ok, outlet_span, outlet_span_ok,
    // meniscus_span, meniscus_span_ok, zero padding
    logic [TDATA_W-1:0]   m_axis_tdata;
    // window_closed
    logic                 m_axis_tuser;

    // Register copies and tracker state of the local model
    logic [CFG_W-1:0]         cfg_window;
    logic [CFG_W-1:0]         cfg_delay;
    logic [CB-1:0]            delay_left;
    logic [CB-1:0]            win_count;
    logic signed [SB-1:0]     trk_min [NS];
    logic signed [SB-1:0]     trk_max [NS];
    logic [NS-1:0]            trk_seen;
    logic [SB-1:0]            span_val [NS];
    logic [NS-1:0]            span_ok;

    t_spans      pending_spans [$];
    int unsigned mismatch_cnt = 0;
    int unsigned idle_cycles  = 0;
    int unsigned burst_left   = 0;
    bit          press_go     = 1'b0;

    windowed_peak_to_peak_monitor_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void clear_tracking();
        delay_left = cfg_delay;
        win_count  = '0;
        trk_seen   = '0;
        span_ok    = '0;
        for (int i = 0; i < NS; i++) begin
            trk_min[i]  = '0;
            trk_max[i]  = '0;
            span_val[i] = '0;
        end
    endfunction

    function automatic t_spans advance_monitor(t_tick t);
        t_spans        r;
        logic [CB:0]   nxt;
        logic signed [SB-1:0] s;
        r = '0;
        if (t.req_type == REQ_RESTART) begin
            clear_tracking();
        end else if (delay_left != 0) begin
            delay_left = delay_left - 1'b1;
        end else begin
            // one bit wider than the counter, so a full-range window still closes
            nxt = {1'b0, win_count} + 1'b1;
            if (nxt > {1'b0, cfg_window}) begin
                for (int i = 0; i < NS; i++) begin
                    span_val[i] = trk_seen[i] ? SB'(trk_max[i] - trk_min[i]) : '0;
                    span_ok[i]  = trk_seen[i];
                    trk_min[i]  = '0;
                    trk_max[i]  = '0;
                end
                trk_seen  = '0;
                win_count = '0;
                r.closed  = 1'b1;
            end else begin
                win_count = nxt[CB-1:0];
            end
            for (int i = 0; i < NS; i++) begin
                if (t.ok[i]) begin
                    s = $signed(t.smp[i]);
                    if (!trk_seen[i] || s < trk_min[i]) trk_min[i] = s;
                    if (!trk_seen[i] || s > trk_max[i]) trk_max[i] = s;
                    trk_seen[i] = 1'b1;
                end
            end
        end
        for (int i = 0; i < NS; i++) begin
            r.span[i] = span_ok[i] ? span_val[i] : '0;
            r.ok[i]   = span_ok[i];
        end
        return r;
    endfunction

    function automatic logic [SB-1:0] draw_sample();
        case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2, 3:    return SB'($urandom_range(0, 64)) - SB'(32);
            default: return SB'($urandom);
        endcase
    endfunction

    // restart_one_in of zero gives sample ticks only
    function automatic t_tick draw_tick(int unsigned restart_one_in);
        t_tick t;
        t.req_type = (restart_one_in != 0 && $urandom_range(1, restart_one_in) == 1)
                     ? REQ_RESTART : REQ_TICK;
        for (int i = 0; i < NS; i++) begin
            t.smp[i] = draw_sample();
            t.ok[i]  = ($urandom_range(0, 4) != 0);
        end
        return t;
    endfunction

    // Offers one tick, waits for the transaction and queues what it should give.
    task automatic send(t_tick t, bit typed, t_spans fixed);
        logic [TDATA_W-1:0] word;
        int unsigned        gap;
        t_spans             predicted;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                      : $urandom_range(1, 16);
        end
        burst_left--;
        word = '0;
        for (int i = 0; i < NS; i++) begin
            word[LANE*i +: SB]   = t.smp[i];
            word[LANE*i + SB]    = t.ok[i];
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= t.req_type;
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = advance_monitor(t);
        pending_spans.push_back(typed ? fixed : predicted);
    endtask

    // Registers change only once every result has come back.
    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] val);
        s_axis_tvalid <= 1'b0;
        while (pending_spans.size() != 0) @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == CFG_WINDOW_TICKS) cfg_window = val;
        else cfg_delay = val;
        @(posedge i_clk);
    endtask

    initial begin
        t_tick  t;
        t_spans fixed;
        cfg_window = WINDOW_TICKS_RST;
        cfg_delay  = START_DELAY_RST;
        clear_tracking();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < ROWS; r++) begin
            if (plan[r].kind == ROW_WRITE) begin
                write_reg(t_cfg_idx'(plan[r].a[CFG_IDX_W-1:0]), plan[r].b);
            end else begin
                t.req_type   = (plan[r].kind == ROW_RESTART) ? REQ_RESTART : REQ_TICK;
                t.ok         = plan[r].ok;
                t.smp        = {plan[r].c, plan[r].b, plan[r].a};
                fixed.closed = plan[r].e_closed;
                fixed.ok     = plan[r].e_ok;
                fixed.span   = {plan[r].e_men, plan[r].e_out, plan[r].e_in};
                send(t, plan[r].typed, fixed);
            end
        end

        // Full-range window: no window may close early.
        write_reg(CFG_WINDOW_TICKS, FULL_WINDOW);
        write_reg(CFG_START_DELAY, '0);
        t = draw_tick(0);
        t.req_type = REQ_RESTART;
        send(t, 1'b0, '0);
        repeat (FULL_ITEMS) send(draw_tick(0), 1'b0, '0);

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case ($urandom_range(0, 9))
                0:       write_reg(CFG_WINDOW_TICKS, '0);
                1:       write_reg(CFG_WINDOW_TICKS, CFG_W'($urandom_range(13, 60)));
                default: write_reg(CFG_WINDOW_TICKS, CFG_W'($urandom_range(1, 8)));
            endcase
            if ($urandom_range(0, 9) == 0) write_reg(CFG_START_DELAY, CFG_W'($urandom_range(20, 200)));
            else write_reg(CFG_START_DELAY, CFG_W'($urandom_range(0, 4)));
            // Without a restart the old count and delay carry into the new setting.
            if ($urandom_range(0, 3) != 0) begin
                t = draw_tick(0);
                t.req_type = REQ_RESTART;
                send(t, 1'b0, '0);
            end
            if (ph == 2) press_go <= 1'b1;
            repeat (PHASE_ITEMS) send(draw_tick(25), 1'b0, '0);
        end

        s_axis_tvalid <= 1'b0;
        while (pending_spans.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("windowed_peak_to_peak_monitor_top_tb passed");
        end else begin
            $display("windowed_peak_to_peak_monitor_top_tb failed");
        end
        $finish;
    end

    // Receiver: changes its stall pattern every so often, and once holds off
    // for a long stretch so that the pipeline fills and stalls the sender.
    int unsigned hold_left  = 0;
    int unsigned mode_left  = 0;
    int unsigned stall_mode = 0;
    bit          press_done = 1'b0;
    bit          toggle     = 1'b0;

    always @(posedge i_clk) begin
        if (press_go && !press_done) begin
            hold_left  = HOLD_CYCLES;
            press_done = 1'b1;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(16, 128);
            end
            mode_left--;
            toggle = !toggle;
            case (stall_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
                2:       m_axis_tready <= toggle;
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_spans got;
        t_spans want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.closed = m_axis_tuser;
            for (int i = 0; i < NS; i++) begin
                got.span[i] = m_axis_tdata[LANE*i +: SB];
                got.ok[i]   = m_axis_tdata[LANE*i + SB];
            end
            if (pending_spans.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= REPORT_MAX)
                    $display("result transaction with no tick outstanding: %h", got);
            end else begin
                want = pending_spans.pop_front();
                if (got !== want) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_MAX) begin
                        $display("span mismatch at %0t", $realtime);
                        $display("  expected in=%h/%b out=%h/%b men=%h/%b closed=%b",
                                 want.span[0], want.ok[0], want.span[1], want.ok[1],
                                 want.span[2], want.ok[2], want.closed);
                        $display("  actual   in=%h/%b out=%h/%b men=%h/%b closed=%b",
                                 got.span[0], got.ok[0], got.span[1], got.ok[1],
                                 got.span[2], got.ok[2], got.closed);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("no transaction for %0d cycles", STALL_LIMIT);
            $display("windowed_peak_to_peak_monitor_top_tb failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
